// ===== design/assert_macros.svh =====
// Assertion macros shared by the range-minimum segment tree modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks a condition at every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed: condition does not hold");
// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication does not hold");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, cond)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/rmst_pkg.sv =====
// Shared constants, types and helper functions of the range-minimum segment tree.
package rmst_pkg;

   localparam int LEAVES      = 1024;
   localparam int ADDR_W      = $clog2(2 * LEAVES);
   localparam int NODE_W      = ADDR_W + 1;
   localparam int POS_W       = 10;
   localparam int END_W       = 11;
   localparam int VAL_W       = 30;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [VAL_W-1:0] SENTINEL = 30'd1000000009;

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_QUERY = 2'd1,
      OP_EMPTY = 2'd2
   } rmst_op_type;

   typedef struct packed {
      rmst_op_type       op;
      logic [NODE_W-1:0] lo;
      logic [NODE_W-1:0] hi;
      logic [VAL_W-1:0]  value;
   } rmst_cmd_type;

   function automatic logic [VAL_W-1:0] min_val(input logic [VAL_W-1:0] a,
                                                input logic [VAL_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

endpackage

// ===== design/rmst_front.sv =====
// Front end: accepts request transactions, classifies them and queues commands.
`include "assert_macros.svh"
module rmst_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [rmst_pkg::POS_W-1:0]  req_position,
   input  logic [rmst_pkg::END_W-1:0]  req_range_end,
   input  logic [rmst_pkg::VAL_W-1:0]  req_new_value,
   input  logic                        clearing,
   output logic                        cmd_valid,
   input  logic                        cmd_pop,
   output rmst_pkg::rmst_cmd_type      cmd
);

   rmst_pkg::rmst_cmd_type          q_ff [rmst_pkg::QUEUE_DEPTH];
   logic [rmst_pkg::QPTR_W-1:0]     wp_ff, wp_in;
   logic [rmst_pkg::QPTR_W-1:0]     rp_ff, rp_in;
   logic [rmst_pkg::QCNT_W-1:0]     cnt_ff, cnt_in;
   rmst_pkg::rmst_cmd_type          cmd_new;
   logic [31:0]                     pos32;
   logic [31:0]                     end_clip;
   logic                            keep;
   logic                            push;

   always_comb begin
      pos32    = 32'(req_position);
      end_clip = (32'(req_range_end) > 32'(rmst_pkg::LEAVES)) ?
                 32'(rmst_pkg::LEAVES) : 32'(req_range_end);
      cmd_new.lo    = rmst_pkg::NODE_W'(pos32 + 32'(rmst_pkg::LEAVES));
      cmd_new.hi    = rmst_pkg::NODE_W'(end_clip + 32'(rmst_pkg::LEAVES));
      cmd_new.value = (req_new_value > rmst_pkg::SENTINEL) ?
                      rmst_pkg::SENTINEL : req_new_value;
      keep = 1'b1;
      if (req_kind == rmst_pkg::KIND_WRITE) begin
         cmd_new.op = rmst_pkg::OP_WRITE;
         keep       = (pos32 < 32'(rmst_pkg::LEAVES));
      end else if (pos32 < end_clip) begin
         cmd_new.op = rmst_pkg::OP_QUERY;
      end else begin
         cmd_new.op = rmst_pkg::OP_EMPTY;
      end
   end

   assign req_ready = !clearing && (cnt_ff < rmst_pkg::QCNT_W'(rmst_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready && keep;
   assign cmd_valid = (cnt_ff != '0);
   assign cmd       = q_ff[rp_ff];

   always_comb begin
      wp_in  = push ? rmst_pkg::QPTR_W'(wp_ff + 1'b1) : wp_ff;
      rp_in  = cmd_pop ? rmst_pkg::QPTR_W'(rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff;
      if (push && !cmd_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && cmd_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cmd_new;
      end
   end

   `ASSERT_ALWAYS(a_queue_bound, clock, reset, cnt_ff <= rmst_pkg::QCNT_W'(rmst_pkg::QUEUE_DEPTH))
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, cmd_pop, cmd_valid)
   `ASSERT_IMPLIES(a_closed_clear, clock, reset, clearing, !req_ready && !cmd_pop)

endmodule

// ===== design/rmst_back.sv =====
// Back end: node memory, clearing pass, update and query walks, result register.
`include "assert_macros.svh"
module rmst_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        cmd_valid,
   output logic                        cmd_pop,
   input  rmst_pkg::rmst_cmd_type      cmd,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rmst_pkg::VAL_W-1:0]  rsp_min_value
);

   typedef enum logic [4:0] {
      S_CLEAR    = 5'b00001,
      S_IDLE     = 5'b00010,
      S_WRITE_UP = 5'b00100,
      S_QUERY    = 5'b01000,
      S_DONE     = 5'b10000
   } rmst_state_type;

   localparam logic [rmst_pkg::ADDR_W-1:0] LAST_ADDR =
      rmst_pkg::ADDR_W'(2 * rmst_pkg::LEAVES - 1);

   logic [rmst_pkg::VAL_W-1:0]  mem [2 * rmst_pkg::LEAVES];

   rmst_state_type              state_ff, state_in;
   logic [rmst_pkg::ADDR_W-1:0] clr_ff, clr_in;
   logic [rmst_pkg::NODE_W-1:0] node_ff, node_in;
   logic [rmst_pkg::NODE_W-1:0] lo_ff, lo_in;
   logic [rmst_pkg::NODE_W-1:0] hi_ff, hi_in;
   logic [rmst_pkg::VAL_W-1:0]  cur_ff, cur_in;
   logic [rmst_pkg::VAL_W-1:0]  best_ff, best_in;
   logic                        rd_valid_ff, rd_valid_in;
   logic [rmst_pkg::VAL_W-1:0]  rd_data_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [rmst_pkg::VAL_W-1:0]  rsp_min_value_ff, rsp_min_value_in;

   logic                        we;
   logic [rmst_pkg::ADDR_W-1:0] wa;
   logic [rmst_pkg::VAL_W-1:0]  wd;
   logic [rmst_pkg::NODE_W-1:0] rnode;
   logic                        rd_issue;
   logic                        rsp_load;
   logic [rmst_pkg::NODE_W-1:0] parent;
   logic [rmst_pkg::NODE_W-1:0] hi_dec;
   logic [rmst_pkg::VAL_W-1:0]  merged;

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      node_in  = node_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      cur_in   = cur_ff;
      best_in  = best_ff;
      we       = 1'b0;
      wa       = '0;
      wd       = rmst_pkg::SENTINEL;
      rnode    = '0;
      rd_issue = 1'b0;
      rsp_load = 1'b0;
      cmd_pop  = 1'b0;
      parent   = node_ff >> 1;
      hi_dec   = hi_ff - 1'b1;
      merged   = rmst_pkg::min_val(cur_ff, rd_data_ff);
      case (state_ff)
         S_CLEAR: begin
            we     = 1'b1;
            wa     = clr_ff;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               case (cmd.op)
                  rmst_pkg::OP_WRITE: begin
                     we       = 1'b1;
                     wa       = cmd.lo[rmst_pkg::ADDR_W-1:0];
                     wd       = cmd.value;
                     cur_in   = cmd.value;
                     node_in  = cmd.lo;
                     rnode    = cmd.lo ^ rmst_pkg::NODE_W'(1);
                     state_in = S_WRITE_UP;
                  end
                  rmst_pkg::OP_QUERY: begin
                     lo_in    = cmd.lo;
                     hi_in    = cmd.hi;
                     best_in  = rmst_pkg::SENTINEL;
                     state_in = S_QUERY;
                  end
                  default: begin
                     best_in  = rmst_pkg::SENTINEL;
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_WRITE_UP: begin
            we      = 1'b1;
            wa      = parent[rmst_pkg::ADDR_W-1:0];
            wd      = merged;
            cur_in  = merged;
            node_in = parent;
            rnode   = parent ^ rmst_pkg::NODE_W'(1);
            if (parent == rmst_pkg::NODE_W'(1)) begin
               state_in = S_IDLE;
            end
         end
         S_QUERY: begin
            if (rd_valid_ff) begin
               best_in = rmst_pkg::min_val(best_ff, rd_data_ff);
            end
            if (lo_ff < hi_ff) begin
               if (lo_ff[0]) begin
                  rnode    = lo_ff;
                  rd_issue = 1'b1;
                  lo_in    = lo_ff + 1'b1;
               end else if (hi_ff[0]) begin
                  rnode    = hi_dec;
                  rd_issue = 1'b1;
                  lo_in    = lo_ff >> 1;
                  hi_in    = hi_dec >> 1;
               end else begin
                  lo_in = lo_ff >> 1;
                  hi_in = hi_ff >> 1;
               end
            end else if (!rd_valid_ff) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_comb begin
      rd_valid_in      = rd_issue;
      rsp_min_value_in = rsp_load ? best_ff : rsp_min_value_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff          <= node_in;
      lo_ff            <= lo_in;
      hi_ff            <= hi_in;
      cur_ff           <= cur_in;
      best_ff          <= best_in;
      rsp_min_value_ff <= rsp_min_value_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rd_data_ff <= mem[rnode[rmst_pkg::ADDR_W-1:0]];
   end

   assign clearing      = (state_ff == S_CLEAR);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_min_value = rsp_min_value_ff;

   `ASSERT_IMPLIES(a_walk_above_root, clock, reset, state_ff == S_WRITE_UP, node_ff > rmst_pkg::NODE_W'(1))
   `ASSERT_IMPLIES(a_read_in_range, clock, reset, rd_issue, lo_ff < hi_ff)
   `ASSERT_IMPLIES(a_load_when_free, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready)

endmodule

// ===== design/range_minimum_segment_tree.sv =====
// Top level of the range-minimum segment tree with point writes.
// After reset the node memory, all 2*LEAVES = 2048 nodes, is cleared one node per cycle,
// with req_ready low; no request transaction is taken until the pass ends.
// A write walks from the leaf up to the root in the back end, one node memory access per level.
// A query walks from the leaf level toward the root, one node read at a time on the single read port.
// A two-entry command queue lets up to two requests wait while the back end is busy.
module range_minimum_segment_tree (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_kind,
   input  logic [rmst_pkg::POS_W-1:0]  req_position,
   input  logic [rmst_pkg::END_W-1:0]  req_range_end,
   input  logic [rmst_pkg::VAL_W-1:0]  req_new_value,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rmst_pkg::VAL_W-1:0]  rsp_min_value
);

   logic                   cmd_valid;
   logic                   cmd_pop;
   logic                   clearing;
   rmst_pkg::rmst_cmd_type cmd;

   rmst_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_position  (req_position),
      .req_range_end (req_range_end),
      .req_new_value (req_new_value),
      .clearing      (clearing),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop),
      .cmd           (cmd)
   );

   rmst_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_pop       (cmd_pop),
      .cmd           (cmd),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_min_value (rsp_min_value)
   );

endmodule

// ===== tb/tb_range_minimum_segment_tree.sv =====
// Self-checking testbench for the range-minimum segment tree with point writes.
module tb_range_minimum_segment_tree;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 1000000;
   localparam int RANDOM_COUNT   = 1200;
   localparam int DIRECTED_COUNT = 21;
   localparam int DRAIN_CYCLES   = 100;
   localparam int HOLD_OFF       = 500;
   localparam logic [rmst_pkg::VAL_W-1:0] TOP_VALUE = 30'd1000000000;

   typedef struct {
      logic                       kind;
      logic [rmst_pkg::POS_W-1:0] position;
      logic [rmst_pkg::END_W-1:0] range_end;
      logic [rmst_pkg::VAL_W-1:0] new_value;
      bit                         typed;
      logic [rmst_pkg::VAL_W-1:0] typed_min;
   } tree_request_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_ready;
   logic                       req_kind;
   logic [rmst_pkg::POS_W-1:0] req_position;
   logic [rmst_pkg::END_W-1:0] req_range_end;
   logic [rmst_pkg::VAL_W-1:0] req_new_value;
   logic                       rsp_valid;
   logic                       rsp_ready;
   logic [rmst_pkg::VAL_W-1:0] rsp_min_value;

   logic [rmst_pkg::VAL_W-1:0] node_min [0:2*rmst_pkg::LEAVES-1];
   tree_request_type           offered_requests [$];
   logic [rmst_pkg::VAL_W-1:0] expected_minima [$];
   int                         failures       = 0;
   int                         responses_seen = 0;
   int                         cycle_count    = 0;

   tree_request_type directed_requests [0:DIRECTED_COUNT-1] = '{
      '{rmst_pkg::KIND_QUERY, 10'd0,    11'd1024, 30'd0,        1'b1, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd0,    11'd2047, 30'h3FFFFFFF, 1'b1, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_WRITE, 10'd0,    11'd0,    30'd0,        1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_WRITE, 10'd1023, 11'd2047, TOP_VALUE,    1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_WRITE, 10'd512,  11'd0,    30'h3FFFFFFF, 1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_WRITE, 10'd5,    11'd0,    rmst_pkg::SENTINEL, 1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_WRITE, 10'd511,  11'd0,    30'd7,        1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd0,    11'd1,    30'd0,        1'b1, 30'd0},
      '{rmst_pkg::KIND_QUERY, 10'd1023, 11'd1024, 30'd0,        1'b1, TOP_VALUE},
      '{rmst_pkg::KIND_QUERY, 10'd512,  11'd513,  30'd0,        1'b1, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd1,    11'd1024, 30'd0,        1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd1,    11'd2047, 30'd0,        1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd5,    11'd5,    30'd0,        1'b1, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd1023, 11'd0,    30'd0,        1'b1, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd1023, 11'd2047, 30'd0,        1'b1, TOP_VALUE},
      '{rmst_pkg::KIND_QUERY, 10'd0,    11'd0,    30'd0,        1'b1, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_WRITE, 10'd0,    11'd1024, rmst_pkg::SENTINEL, 1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd0,    11'd1024, 30'd0,        1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_WRITE, 10'd341,  11'd1365, 30'h15555555, 1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd341,  11'd683,  30'h2AAAAAAA, 1'b0, rmst_pkg::SENTINEL},
      '{rmst_pkg::KIND_QUERY, 10'd1023, 11'd1023, 30'd0,        1'b1, rmst_pkg::SENTINEL}
   };

   range_minimum_segment_tree dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_position  (req_position),
      .req_range_end (req_range_end),
      .req_new_value (req_new_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_min_value (rsp_min_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [rmst_pkg::VAL_W-1:0] lesser(
      input logic [rmst_pkg::VAL_W-1:0] a,
      input logic [rmst_pkg::VAL_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic void store_leaf(input logic [rmst_pkg::POS_W-1:0] position,
                                      input logic [rmst_pkg::VAL_W-1:0] value);
      int node;
      logic [rmst_pkg::VAL_W-1:0] stored;
      if (position >= rmst_pkg::LEAVES) return;
      stored = (value > rmst_pkg::SENTINEL) ? rmst_pkg::SENTINEL : value;
      node = int'(position) + rmst_pkg::LEAVES;
      node_min[rmst_pkg::ADDR_W'(node)] = stored;
      node = node >> 1;
      while (node >= 1) begin
         node_min[rmst_pkg::ADDR_W'(node)] =
            lesser(node_min[rmst_pkg::ADDR_W'(2*node)], node_min[rmst_pkg::ADDR_W'(2*node+1)]);
         node = node >> 1;
      end
   endfunction

   function automatic logic [rmst_pkg::VAL_W-1:0] range_minimum(
      input logic [rmst_pkg::POS_W-1:0] first,
      input logic [rmst_pkg::END_W-1:0] stop);
      int lo;
      int hi;
      logic [rmst_pkg::VAL_W-1:0] best;
      best = rmst_pkg::SENTINEL;
      lo = int'(first);
      hi = (int'(stop) > rmst_pkg::LEAVES) ? rmst_pkg::LEAVES : int'(stop);
      if (lo < hi) begin
         lo += rmst_pkg::LEAVES;
         hi += rmst_pkg::LEAVES;
         while (lo < hi) begin
            if (lo & 1) begin
               best = lesser(best, node_min[rmst_pkg::ADDR_W'(lo)]);
               lo++;
            end
            if (hi & 1) begin
               hi--;
               best = lesser(best, node_min[rmst_pkg::ADDR_W'(hi)]);
            end
            lo = lo >> 1;
            hi = hi >> 1;
         end
      end
      return best;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 4);
      return $urandom_range(20, 80);
   endfunction

   function automatic logic [rmst_pkg::POS_W-1:0] random_position();
      if ($urandom_range(0, 1)) return rmst_pkg::POS_W'($urandom_range(0, 63));
      return rmst_pkg::POS_W'($urandom_range(0, rmst_pkg::LEAVES - 1));
   endfunction

   function automatic tree_request_type random_request();
      tree_request_type request;
      int r;
      request.typed     = 1'b0;
      request.typed_min = rmst_pkg::SENTINEL;
      request.position  = random_position();
      request.range_end = rmst_pkg::END_W'($urandom_range(0, 2047));
      request.new_value = rmst_pkg::VAL_W'($urandom);
      r = $urandom_range(0, 9);
      if ($urandom_range(0, 9) < 4) begin
         request.kind = rmst_pkg::KIND_WRITE;
         if (r < 7) begin
            request.new_value = rmst_pkg::VAL_W'($urandom_range(0, TOP_VALUE));
         end else if (r == 7) begin
            request.new_value = rmst_pkg::VAL_W'($urandom_range(0, 1000));
         end else if (r == 9) begin
            request.new_value = rmst_pkg::VAL_W'($urandom_range(999999990, 1000000020));
         end
      end else begin
         request.kind = rmst_pkg::KIND_QUERY;
         if (r < 6) begin
            request.range_end =
               rmst_pkg::END_W'(32'(request.position) + $urandom_range(1, 64));
         end else if (r == 7) begin
            request.range_end = rmst_pkg::END_W'($urandom_range(1024, 2047));
         end else if (r == 8) begin
            request.range_end = rmst_pkg::END_W'($urandom_range(0, request.position));
         end else if (r == 9) begin
            request.range_end =
               rmst_pkg::END_W'(32'(request.position) + $urandom_range(1, 1024));
         end
      end
      return request;
   endfunction

   task automatic send_request(input tree_request_type request, input int gap);
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      offered_requests.push_back(request);
      req_valid     <= 1'b1;
      req_kind      <= request.kind;
      req_position  <= request.position;
      req_range_end <= request.range_end;
      req_new_value <= request.new_value;
      do @(posedge clock); while (!req_ready);
   endtask

   always @(posedge clock) begin : monitor
      tree_request_type accepted;
      logic [rmst_pkg::VAL_W-1:0] predicted;
      logic [rmst_pkg::VAL_W-1:0] wanted_min;
      if (!reset && req_valid && req_ready) begin
         accepted = offered_requests.pop_front();
         if (accepted.kind == rmst_pkg::KIND_WRITE) begin
            store_leaf(accepted.position, accepted.new_value);
         end else begin
            predicted = range_minimum(accepted.position, accepted.range_end);
            expected_minima.push_back(accepted.typed ? accepted.typed_min : predicted);
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (expected_minima.size() == 0) begin
            failures++;
            $error("unexpected transaction: min_value actual %0d", rsp_min_value);
         end else begin
            wanted_min = expected_minima.pop_front();
            if (rsp_min_value !== wanted_min) begin
               failures++;
               $error("min_value mismatch: expected %0d actual %0d", wanted_min,
                      rsp_min_value);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : receiver
      bit held_off;
      int r;
      rsp_ready = 1'b0;
      held_off  = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!held_off && responses_seen >= 40) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF) @(negedge clock);
         end else begin
            r = $urandom_range(0, 9);
            if (r < 4) begin
               rsp_ready <= 1'b1;
               repeat ($urandom_range(1, 40)) @(negedge clock);
            end else if (r < 9) begin
               rsp_ready <= 1'($urandom_range(0, 1));
               repeat ($urandom_range(1, 3)) @(negedge clock);
            end else begin
               rsp_ready <= 1'b0;
               repeat ($urandom_range(10, 60)) @(negedge clock);
            end
         end
      end
   end

   initial begin : sender
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_kind      = rmst_pkg::KIND_WRITE;
      req_position  = '0;
      req_range_end = '0;
      req_new_value = '0;
      for (int k = 0; k < 2*rmst_pkg::LEAVES; k++) begin
         node_min[rmst_pkg::ADDR_W'(k)] = rmst_pkg::SENTINEL;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIRECTED_COUNT; i++) send_request(directed_requests[i], pick_gap());
      for (int i = 0; i < RANDOM_COUNT; i++) send_request(random_request(), pick_gap());
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_minima.size() != 0 || offered_requests.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
